FILE: sv/torus_bubble_route_select_defines.svh
// Assertion macros for the torus route select block.
// Used by the top level; no other dependencies.
`ifndef TORUS_BUBBLE_ROUTE_SELECT_DEFINES_SVH
`define TORUS_BUBBLE_ROUTE_SELECT_DEFINES_SVH
`ifndef SYNTHESIS
`define TBRS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define TBRS_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition");
`else
`define TBRS_ASSERT(label, prop)
`define TBRS_ASSERT_NEVER(label, expr)
`endif
`endif

FILE: sv/tbrs_pkg.sv
// Package for the torus route select block: sizes, command and action codes.
// No dependencies.
package tbrs_pkg;
  localparam int unsigned MaxRing = 16;
  localparam int unsigned QueueCount = 12;

  typedef enum logic [1:0] {
    CMD_PACKET = 2'd0,
    CMD_ACK    = 2'd1,
    CMD_DRAIN  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ACT_ADAPTIVE = 3'd0,
    ACT_ESCAPE   = 3'd1,
    ACT_CONSUMED = 3'd2,
    ACT_CORRUPT  = 3'd3,
    ACT_FULL     = 3'd4,
    ACT_BOOK     = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    REG_RING_X   = 3'd0,
    REG_RING_Y   = 3'd1,
    REG_RING_Z   = 3'd2,
    REG_NODE     = 3'd3,
    REG_ESC_CAP  = 3'd4,
    REG_ADA_CAP  = 3'd5,
    REG_CONS_CAP = 3'd6
  } reg_e;
endpackage

FILE: sv/torus_bubble_route_select.sv
// Routing and credit unit of one 3D torus node, bubble flow control.
// Depends on tbrs_pkg and torus_bubble_route_select_defines.svh.
//
// Usage: one input transaction (cmd plus packet fields) is taken on the
// in channel when in_valid_i and in_ready_o are high; exactly one result
// transaction (action, chosen_queue) follows on the out channel.
// ACK, drain, unknown and corrupt transactions skip the divider and go
// straight to the result state. A packet is decoded by one shared restoring
// divider, one quotient bit a cycle, in six divisions of 12 bits (node and
// destination, three rings each), then passes the direction compare, the
// queue selection and the result register before its result is valid.
// Only one transaction is in flight; in_ready_o is low from accept
// until the result has been taken, so the block takes no new transaction
// before it is through with the last one.
// The result waits in an output register while out_ready_i is low; the
// block then holds and accepts nothing new.
// Reset sets the registers to rings of 4, node 0, escape and adaptive
// capacity 4, consume capacity 8, fills every credit counter to its
// class capacity and empties the consume queue.
// Configuration writes go through the APB port at byte address 4*index.
`include "torus_bubble_route_select_defines.svh"
module torus_bubble_route_select
  import tbrs_pkg::*;
#(
  parameter int unsigned MAX_RING = MaxRing
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [11:0] dest_address_i,
  input  logic [3:0]  came_from_queue_i,
  input  logic        injected_i,
  input  logic        bit_error_i,
  input  logic [3:0]  credit_queue_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  action_o,
  output logic [3:0]  chosen_queue_o
);
  localparam int unsigned KW = $clog2(MAX_RING + 1);
  localparam int unsigned CW = $clog2(MAX_RING);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_DIR, ST_SEL, ST_OUT
  } state_e;

  // Configuration registers.
  logic [4:0]  ring_q [3];
  logic [11:0] node_q;
  logic [7:0]  esc_cap_q, ada_cap_q, cons_cap_q;
  logic [7:0]  free_q [QueueCount];
  logic [7:0]  occ_q;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  // Register read back.
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_RING_X:   prdata = {27'd0, ring_q[0]};
      REG_RING_Y:   prdata = {27'd0, ring_q[1]};
      REG_RING_Z:   prdata = {27'd0, ring_q[2]};
      REG_NODE:     prdata = {20'd0, node_q};
      REG_ESC_CAP:  prdata = {24'd0, esc_cap_q};
      REG_ADA_CAP:  prdata = {24'd0, ada_cap_q};
      REG_CONS_CAP: prdata = {24'd0, cons_cap_q};
      default:      prdata = '0;
    endcase
  end

  // Ring sizes clamped into the supported range.
  logic [KW-1:0] ring_k [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ring_q[i] < 5'd2) ring_k[i] = KW'(2);
      else if (32'(ring_q[i]) > MAX_RING) ring_k[i] = KW'(MAX_RING);
      else ring_k[i] = KW'(ring_q[i]);
    end
  end

  // Latched transaction.
  logic [1:0]  cmd_q;
  logic [11:0] dest_q;
  logic [3:0]  from_q, credit_q;
  logic        inj_q;

  // Shared divider state: dividend/quotient shift, partial remainder.
  state_e       state_q;
  logic [11:0]  quo_q;
  logic [KW-1:0] rem_q;
  logic [3:0]   bit_q;
  logic [2:0]   div_q;      // 0..5: node x,y,z then dest x,y,z
  logic [CW-1:0] me_q [3];
  logic [CW-1:0] dst_q [3];
  logic [2:0]   dirs_q [3];
  logic [1:0]   ndir_q;
  logic [2:0]   act_q;
  logic [3:0]   chq_q;
  logic         out_valid_q;

  logic [1:0]   dim;
  logic [KW-1:0] kdiv;
  logic [KW:0]  trial;
  logic         ge;
  assign dim   = (div_q >= 3'd3) ? 2'(div_q - 3'd3) : div_q[1:0];
  assign kdiv  = ring_k[dim];
  assign trial = {rem_q, quo_q[11]};
  assign ge    = trial >= {1'b0, kdiv};

  // Direction per dimension from the decoded coordinates.
  logic [KW:0] hops [3];
  logic [KW:0] dsum [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsum[i] = (KW+1)'(ring_k[i]) + (KW+1)'(dst_q[i]) - (KW+1)'(me_q[i]);
      hops[i] = (dsum[i] >= (KW+1)'(ring_k[i])) ? dsum[i] - (KW+1)'(ring_k[i])
                                                 : dsum[i];
    end
  end

  // Adaptive pick and escape check on the latched directions.
  logic [7:0] best_fs;
  logic [3:0] best_q;
  logic [3:0] aq;
  logic [3:0] eq;
  logic       same;
  always_comb begin
    best_fs = '0;
    best_q  = '0;
    aq      = '0;
    for (int i = 0; i < 3; i++) begin
      aq = {dirs_q[i], 1'b1};
      if (2'(i) < ndir_q && free_q[aq] > best_fs) begin
        best_fs = free_q[aq];
        best_q  = aq;
      end
    end
  end
  assign eq   = {dirs_q[0], 1'b0};
  assign same = !inj_q && (from_q == eq);

  assign in_ready_o  = (state_q == ST_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign action_o    = act_q;
  assign chosen_queue_o = chq_q;

  // Sequencer, divider and credit state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ring_q[0] <= 5'd4; ring_q[1] <= 5'd4; ring_q[2] <= 5'd4;
      node_q    <= '0;
      esc_cap_q <= 8'd4; ada_cap_q <= 8'd4; cons_cap_q <= 8'd8;
      for (int q = 0; q < QueueCount; q++) free_q[q] <= 8'd4;
      occ_q  <= '0;
      div_q  <= '0;
      bit_q  <= '0;
      ndir_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_RING_X:   ring_q[0] <= pwdata[4:0];
          REG_RING_Y:   ring_q[1] <= pwdata[4:0];
          REG_RING_Z:   ring_q[2] <= pwdata[4:0];
          REG_NODE:     node_q <= pwdata[11:0];
          REG_ESC_CAP: begin
            esc_cap_q <= pwdata[7:0];
            for (int q = 0; q < QueueCount; q += 2) free_q[q] <= pwdata[7:0];
          end
          REG_ADA_CAP: begin
            ada_cap_q <= pwdata[7:0];
            for (int q = 1; q < QueueCount; q += 2) free_q[q] <= pwdata[7:0];
          end
          REG_CONS_CAP: cons_cap_q <= pwdata[7:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            cmd_q <= cmd_i; dest_q <= dest_address_i; from_q <= came_from_queue_i;
            inj_q <= injected_i; credit_q <= credit_queue_i;
            chq_q <= '0;
            if (cmd_i == CMD_PACKET && !bit_error_i) begin
              quo_q <= node_q; rem_q <= '0; bit_q <= '0; div_q <= '0;
              state_q <= ST_DIV;
            end else begin
              act_q   <= (cmd_i == CMD_PACKET) ? ACT_CORRUPT : ACT_BOOK;
              state_q <= ST_OUT;
            end
          end
        end
        ST_DIV: begin
          // One quotient bit per cycle.
          if (bit_q == 4'd11) begin
            bit_q <= '0;
            rem_q <= '0;
            if (div_q == 3'd2) quo_q <= dest_q;
            else quo_q <= {quo_q[10:0], ge};
            if (div_q < 3'd3) me_q[dim] <= CW'(ge ? trial - {1'b0, kdiv} : trial);
            else dst_q[dim] <= CW'(ge ? trial - {1'b0, kdiv} : trial);
            div_q <= div_q + 3'd1;
            if (div_q == 3'd5) state_q <= ST_DIR;
          end else begin
            quo_q <= {quo_q[10:0], ge};
            rem_q <= ge ? KW'(trial - {1'b0, kdiv}) : KW'(trial);
            bit_q <= bit_q + 4'd1;
          end
        end
        ST_DIR: begin
          // Collect the differing dimensions in order.
          logic [1:0] n;
          n = '0;
          for (int i = 0; i < 3; i++) begin
            if (hops[i] != '0) begin
              dirs_q[n] <= {2'(i), (hops[i] <= (KW+1)'(ring_k[i] >> 1)) ? 1'b0 : 1'b1};
              n = n + 2'd1;
            end
          end
          ndir_q  <= n;
          state_q <= ST_SEL;
        end
        ST_SEL: begin
          if (ndir_q == '0) begin
            if (occ_q >= cons_cap_q) act_q <= ACT_FULL;
            else begin
              occ_q <= occ_q + 8'd1;
              act_q <= ACT_CONSUMED;
            end
          end else if (best_fs != '0) begin
            free_q[best_q] <= free_q[best_q] - 8'd1;
            act_q <= ACT_ADAPTIVE; chq_q <= best_q;
          end else if (free_q[eq] == '0 || (!same && free_q[eq] < 8'd2)) begin
            act_q <= ACT_FULL;
          end else begin
            free_q[eq] <= free_q[eq] - 8'd1;
            act_q <= ACT_ESCAPE; chq_q <= eq;
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (cmd_q == CMD_ACK && credit_q < 4'(QueueCount)) begin
            if (free_q[credit_q] < (credit_q[0] ? ada_cap_q : esc_cap_q))
              free_q[credit_q] <= free_q[credit_q] + 8'd1;
          end else if (cmd_q == CMD_DRAIN && occ_q != '0) begin
            occ_q <= occ_q - 8'd1;
          end
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Checks on the sequencer.
  `TBRS_ASSERT(a_one_in_flight, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `TBRS_ASSERT(a_out_after_done, (state_q == ST_OUT) |=> out_valid_o)
  `TBRS_ASSERT_NEVER(a_no_busy_valid, out_valid_o && state_q != ST_IDLE)
  `TBRS_ASSERT(a_chosen_zero,
    (out_valid_o && action_o != ACT_ADAPTIVE && action_o != ACT_ESCAPE)
    |-> (chosen_queue_o == 4'd0))
endmodule

FILE: tb/tb.sv
// Testbench for torus_bubble_route_select: random and directed transactions,
// with an in-testbench routing and credit predictor. Depends on tbrs_pkg.
module tb
  import tbrs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Predicts routing decisions and keeps expected results in order.
  class route_scoreboard;
    logic [4:0] ring_x, ring_y, ring_z;
    logic [11:0] node_addr;
    logic [7:0] esc_cap, ada_cap, cons_cap;
    logic [7:0] slots [QueueCount];
    logic [7:0] cons_occ;
    action_e exp_action [$];
    logic [3:0] exp_queue [$];
    int errors;

    function new();
      ring_x = 4; ring_y = 4; ring_z = 4; node_addr = 0;
      esc_cap = 4; ada_cap = 4; cons_cap = 8; cons_occ = 0; errors = 0;
      for (int q = 0; q < QueueCount; q++) slots[q] = 4;
    endfunction

    function void write_reg(reg_e idx, logic [31:0] v);
      case (idx)
        REG_RING_X: ring_x = v[4:0];
        REG_RING_Y: ring_y = v[4:0];
        REG_RING_Z: ring_z = v[4:0];
        REG_NODE: node_addr = v[11:0];
        REG_ESC_CAP: begin
          esc_cap = v[7:0];
          for (int q = 0; q < QueueCount; q += 2) slots[q] = esc_cap;
        end
        REG_ADA_CAP: begin
          ada_cap = v[7:0];
          for (int q = 1; q < QueueCount; q += 2) slots[q] = ada_cap;
        end
        REG_CONS_CAP: cons_cap = v[7:0];
        default: ;
      endcase
    endfunction

    function int clamp_ring(int k);
      if (k < 2) return 2;
      if (k > MaxRing) return MaxRing;
      return k;
    endfunction

    // Notes one accepted input transaction and computes its result.
    function void note_input(cmd_e cmd, logic [11:0] dest, logic [3:0] from_q,
                             logic inj, logic berr, logic [3:0] credit_q);
      int k [3];
      int me [3];
      int dst [3];
      int dirs [3];
      int n, a, b, d, best_q, eq;
      logic [7:0] best_fs;
      action_e act;
      logic [3:0] chosen;
      act = ACT_BOOK; chosen = 0; n = 0;
      if (cmd == CMD_PACKET) begin
        if (berr) act = ACT_CORRUPT;
        else begin
          k[0] = clamp_ring(ring_x); k[1] = clamp_ring(ring_y);
          k[2] = clamp_ring(ring_z);
          a = node_addr; b = dest;
          for (int i = 0; i < 3; i++) begin
            me[i] = a % k[i]; a = a / k[i];
            dst[i] = b % k[i]; b = b / k[i];
          end
          for (int i = 0; i < 3; i++) begin
            d = (k[i] + dst[i] - me[i]) % k[i];
            if (d != 0) begin
              dirs[n] = 2 * i + ((d <= k[i] / 2) ? 0 : 1);
              n++;
            end
          end
          if (n == 0) begin
            if (cons_occ >= cons_cap) act = ACT_FULL;
            else begin
              cons_occ++;
              act = ACT_CONSUMED;
            end
          end else begin
            best_fs = 0; best_q = -1;
            for (int i = 0; i < n; i++)
              if (slots[1 + 2 * dirs[i]] > best_fs) begin
                best_fs = slots[1 + 2 * dirs[i]];
                best_q = 1 + 2 * dirs[i];
              end
            if (best_q >= 0) begin
              slots[best_q]--;
              act = ACT_ADAPTIVE; chosen = 4'(best_q);
            end else begin
              // Bubble rule: one slot when staying in the escape ring, else two.
              eq = 2 * dirs[0];
              if (slots[eq] == 0 || (!(!inj && from_q == eq) && slots[eq] < 2))
                act = ACT_FULL;
              else begin
                slots[eq]--;
                act = ACT_ESCAPE; chosen = 4'(eq);
              end
            end
          end
        end
      end else if (cmd == CMD_ACK) begin
        if (credit_q < QueueCount &&
            slots[credit_q] < (credit_q[0] ? ada_cap : esc_cap))
          slots[credit_q]++;
      end else if (cmd == CMD_DRAIN) begin
        if (cons_occ > 0) cons_occ--;
      end
      exp_action = {exp_action, act};
      exp_queue = {exp_queue, chosen};
    endfunction

    function void check_result(logic [2:0] act, logic [3:0] q);
      if (exp_action.size() == 0) begin
        $display("%0t: unexpected result action=%0d queue=%0d", $time, act, q);
        errors++;
        return;
      end
      if (act !== exp_action[0]) begin
        $display("%0t: action expected %0d actual %0d", $time, exp_action[0], act);
        errors++;
      end
      if (q !== exp_queue[0]) begin
        $display("%0t: chosen_queue expected %0d actual %0d", $time, exp_queue[0], q);
        errors++;
      end
      void'(exp_action.pop_front());
      void'(exp_queue.pop_front());
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;
  logic in_valid_i = 0, in_ready_o;
  logic [1:0] cmd_i = 0;
  logic [11:0] dest_address_i = 0;
  logic [3:0] came_from_queue_i = 0, credit_queue_i = 0;
  logic injected_i = 0, bit_error_i = 0;
  logic out_valid_o, out_ready_i = 0;
  logic [2:0] action_o;
  logic [3:0] chosen_queue_o;
  logic sink_idle_ok = 1;
  route_scoreboard sb;

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  torus_bubble_route_select u_top (.*);

  // Result side: random stalls except in the quiet stretch.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(action_o, chosen_queue_o);
    out_ready_i <= !(sink_idle_ok && $urandom_range(99) < 12);
  end

  task automatic reg_write(reg_e idx, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(4 * idx); pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.write_reg(idx, v);
  endtask

  // Sends one transaction and waits for acceptance, idling first at random.
  // Valid drops after acceptance, while the block is busy anyway.
  task automatic send(cmd_e cmd, logic [11:0] dest, logic [3:0] from_q,
                      logic inj, logic berr, logic [3:0] credit_q, bit may_idle);
    while (may_idle && $urandom_range(99) < 12) @(posedge clk_i);
    in_valid_i <= 1; cmd_i <= cmd; dest_address_i <= dest;
    came_from_queue_i <= from_q; injected_i <= inj; bit_error_i <= berr;
    credit_queue_i <= credit_q;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(cmd, dest, from_q, inj, berr, credit_q);
    in_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    while (sb.exp_action.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // Mostly packets; ACKs keep credits flowing, drains empty the consume queue.
  task automatic random_item(int dest_max, bit may_idle);
    int r;
    r = $urandom_range(99);
    if (r < 55)
      send(CMD_PACKET, 12'($urandom_range(dest_max)), 4'($urandom_range(15)),
           1'($urandom), 1'($urandom_range(9) == 0), 4'($urandom), may_idle);
    else if (r < 80)
      send(CMD_ACK, 12'($urandom), 4'($urandom), 1'($urandom), 1'($urandom),
           4'($urandom_range(15)), may_idle);
    else if (r < 95)
      send(CMD_DRAIN, 12'($urandom), 4'($urandom), 1'($urandom), 1'($urandom),
           4'($urandom), may_idle);
    else
      send(CMD_NONE, 12'($urandom), 4'($urandom), 1'($urandom), 1'($urandom),
           4'($urandom), may_idle);
  endtask

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    int dmax;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    // Directed: defaults, extremes of fields, every command, special cases.
    send(CMD_PACKET, 12'd0, 0, 0, 1, 0, 0);
    for (int i = 0; i < 9; i++) send(CMD_PACKET, 12'd0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 10; i++) send(CMD_DRAIN, 0, 0, 0, 0, 0, 0);
    send(CMD_PACKET, 12'hFFF, 4'hF, 1, 0, 4'hF, 0);
    send(CMD_PACKET, 12'd64, 0, 0, 0, 0, 0);
    send(CMD_ACK, 0, 0, 0, 0, 4'd1, 0);
    send(CMD_ACK, 0, 0, 0, 0, 4'd15, 0);
    send(CMD_NONE, 12'hFFF, 4'hF, 1, 1, 4'hF, 0);
    drain_results();
    // Escape fallback and bubble rule with adaptive queues of one slot.
    reg_write(REG_ADA_CAP, 1);
    reg_write(REG_ESC_CAP, 2);
    reg_write(REG_RING_X, 0);
    send(CMD_PACKET, 12'd1, 0, 0, 0, 0, 0);
    send(CMD_PACKET, 12'd1, 0, 1, 0, 0, 0);
    send(CMD_PACKET, 12'd1, 0, 0, 0, 0, 0);
    send(CMD_PACKET, 12'd1, 0, 1, 0, 0, 0);
    drain_results();
    // Random phases over several settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          reg_write(REG_RING_X, 2); reg_write(REG_RING_Y, 2); reg_write(REG_RING_Z, 2);
          reg_write(REG_NODE, 0); reg_write(REG_ESC_CAP, 1); reg_write(REG_ADA_CAP, 1);
          reg_write(REG_CONS_CAP, 1);
        end
        1: begin
          reg_write(REG_RING_X, 16); reg_write(REG_RING_Y, 16);
          reg_write(REG_RING_Z, 16); reg_write(REG_NODE, 4095);
          reg_write(REG_ESC_CAP, 255); reg_write(REG_ADA_CAP, 255);
          reg_write(REG_CONS_CAP, 255);
        end
        2: begin
          reg_write(REG_RING_X, 31); reg_write(REG_RING_Y, 1); reg_write(REG_RING_Z, 0);
          reg_write(REG_NODE, 12'($urandom));
        end
        default: begin
          reg_write(REG_RING_X, $urandom_range(2, 5));
          reg_write(REG_RING_Y, $urandom_range(2, 5));
          reg_write(REG_RING_Z, $urandom_range(2, 5));
          reg_write(REG_NODE, $urandom_range(0, 200));
          reg_write(REG_ESC_CAP, $urandom_range(1, 3));
          reg_write(REG_ADA_CAP, $urandom_range(1, 3));
          reg_write(REG_CONS_CAP, $urandom_range(1, 4));
        end
      endcase
      dmax = (ph == 1 || ph == 2) ? 4095 : 255;
      sink_idle_ok <= (ph != 4);
      for (int i = 0; i < 300; i++) begin
        random_item(dmax, ph != 4);
        // Hold off until the block has returned every pending result.
        if (i == 150) while (sb.exp_action.size() != 0) @(posedge clk_i);
      end
      drain_results();
    end
    if (sb.errors == 0 && sb.exp_action.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule
